// ===== rtl/sliding_window_median_filter_macros.svh =====
// Assertion macros shared by the median filter RTL.
`ifndef SLIDING_WINDOW_MEDIAN_FILTER_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_FILTER_MACROS_SVH

// Check cons in the same cycle as ante.
`define SWMF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("median filter check failed");

// Check cons in the cycle after ante.
`define SWMF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("median filter check failed");

`endif

// ===== rtl/swmf_pkg.sv =====
// Shared types, constants and width helpers for the median filter.
package swmf_pkg;

    localparam int LEN_BITS = 5;
    localparam logic [LEN_BITS-1:0] LEN_RESET = 5'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_COUNT,
        S_PICK,
        S_SUM
    } t_state;

    typedef struct packed {
        logic shift;
        logic load;
        logic count;
        logic pick;
        logic sum;
    } t_cell_ctrl;

    // Bits for a cell index or a rank (at least one).
    function automatic int f_idx_bits(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    // Bits for an effective window length, never narrower than the register.
    function automatic int f_len_bits(input int n);
        int w;
        w = $clog2(n + 1);
        return (w > LEN_BITS) ? w : LEN_BITS;
    endfunction

endpackage

// ===== rtl/sliding_window_median_filter.sv =====
// Top level of the sliding-window running median filter.
//
// Usage:
//   Input channel i_valid/o_ready carries one signed sample per beat on
//   i_sample. Output channel o_valid/i_ready carries one beat per input
//   beat on o_median_doubled: twice the median of the newest window_length
//   samples (the sum of the two middle values for an even length).
//   i_cfg_we/i_cfg_wdata write window_length at once; write it only while
//   no sample is in flight. Zero acts as one, above MAX_WINDOW as MAX_WINDOW.
// Timing:
//   The next sample is accepted only once a beat has passed the load,
//   rank count, pick and sum phases. The rank count dominates: every
//   cell's copy passes the other MAX_WINDOW - 1 cells, one hop per cycle,
//   while each cell counts how many active samples rank below its own.
//   The result is registered in the sum phase and then shows on o_valid.
// Reset:
//   Clears the history to zero (those zeros count until displaced), sets
//   window_length to 5 and empties the output register.
// Backpressure:
//   The output register holds a finished result while i_ready is low; the
//   next sample is still taken and ranked, then waits in the sum phase.
`include "sliding_window_median_filter_macros.svh"

module sliding_window_median_filter
    import swmf_pkg::*;
#(
    parameter int MAX_WINDOW  = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [SAMPLE_BITS:0]   o_median_doubled,
    input  logic                          i_cfg_we,
    input  logic [LEN_BITS-1:0]           i_cfg_wdata
);

    localparam int IDXW = f_idx_bits(MAX_WINDOW);
    localparam int LW   = f_len_bits(MAX_WINDOW);
    localparam logic [LW-1:0] LEN_MAX = LW'(MAX_WINDOW);

    // Window length register.
    logic [LEN_BITS-1:0] r_len;
    logic [LW-1:0]       w_len_raw;
    logic [LW-1:0]       w_len;
    logic [LW-1:0]       w_lo_rank;
    logic [LW-1:0]       w_hi_rank;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_RESET;
        end else if (i_cfg_we) begin
            r_len <= i_cfg_wdata;
        end
    end

    // Clamp the length, then find the ranks of the two middle values.
    // For an odd length both ranks name the same cell.
    assign w_len_raw = LW'(r_len);
    assign w_len     = (w_len_raw == '0)     ? LW'(1)  :
                       (w_len_raw > LEN_MAX) ? LEN_MAX : w_len_raw;
    assign w_lo_rank = (w_len - LW'(1)) >> 1;
    assign w_hi_rank = w_len >> 1;

    // Sequencer.
    t_cell_ctrl w_ctrl;
    logic       w_out_free;
    logic       w_out_load;

    swmf_ctrl #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .o_ctrl     (w_ctrl),
        .i_out_free (w_out_free)
    );

    // Cell chain: slot 0 holds the newest sample; the compare ring wraps.
    logic signed [SAMPLE_BITS-1:0] w_sample   [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] w_ring_val [MAX_WINDOW];
    logic [IDXW-1:0]               w_ring_idx [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0]        w_hit_lo   [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0]        w_hit_hi   [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]         w_match_lo;
    logic [MAX_WINDOW-1:0]         w_match_hi;

    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        localparam int PREV = (g == 0) ? MAX_WINDOW - 1 : g - 1;
        logic signed [SAMPLE_BITS-1:0] w_shift_in;

        if (g == 0) begin : g_head
            assign w_shift_in = i_sample;
        end else begin : g_body
            assign w_shift_in = w_sample[g-1];
        end

        swmf_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .MAX_WINDOW  (MAX_WINDOW),
            .CELL_IDX    (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (w_ctrl),
            .i_len         (w_len),
            .i_lo_rank     (w_lo_rank),
            .i_hi_rank     (w_hi_rank),
            .i_shift_in    (w_shift_in),
            .i_ring_sample (w_sample[PREV]),
            .i_ring_val    (w_ring_val[PREV]),
            .i_ring_idx    (w_ring_idx[PREV]),
            .o_sample      (w_sample[g]),
            .o_ring_val    (w_ring_val[g]),
            .o_ring_idx    (w_ring_idx[g]),
            .o_hit_lo      (w_hit_lo[g]),
            .o_hit_hi      (w_hit_hi[g]),
            .o_match_lo    (w_match_lo[g]),
            .o_match_hi    (w_match_hi[g])
        );
    end

    // Exactly one cell holds each middle value; the others drive zero.
    logic [SAMPLE_BITS-1:0]      w_or_lo;
    logic [SAMPLE_BITS-1:0]      w_or_hi;
    logic signed [SAMPLE_BITS:0] w_sum;

    always_comb begin
        w_or_lo = '0;
        w_or_hi = '0;
        for (int k = 0; k < MAX_WINDOW; k++) begin
            w_or_lo = w_or_lo | w_hit_lo[k];
            w_or_hi = w_or_hi | w_hit_hi[k];
        end
    end

    assign w_sum = $signed({w_or_lo[SAMPLE_BITS-1], w_or_lo}) +
                   $signed({w_or_hi[SAMPLE_BITS-1], w_or_hi});

    // Output register: load when empty or being drained this cycle.
    logic                        r_out_valid;
    logic signed [SAMPLE_BITS:0] r_out_data;

    assign w_out_free = !r_out_valid || i_ready;
    assign w_out_load = w_ctrl.sum && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= w_sum;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_median_doubled = r_out_data;

    // An accepted beat starts the ring load in the next cycle.
    `SWMF_ASSERT_NEXT(a_accept_loads, i_clk, i_rst_n, i_valid && o_ready, w_ctrl.load)
    // Ranks among active cells are unique, so each middle rank has one owner.
    `SWMF_ASSERT_NOW(a_lo_unique, i_clk, i_rst_n, w_ctrl.sum, $onehot(w_match_lo))
    `SWMF_ASSERT_NOW(a_hi_unique, i_clk, i_rst_n, w_ctrl.sum, $onehot(w_match_hi))

endmodule

// ===== rtl/swmf_cell.sv =====
// One window cell: history slot, rotating compare copy and rank counter.
module swmf_cell
    import swmf_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_WINDOW  = 16,
    parameter int CELL_IDX    = 0
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  t_cell_ctrl                                 i_ctrl,
    input  logic [f_len_bits(MAX_WINDOW)-1:0]          i_len,
    input  logic [f_len_bits(MAX_WINDOW)-1:0]          i_lo_rank,
    input  logic [f_len_bits(MAX_WINDOW)-1:0]          i_hi_rank,
    input  logic signed [SAMPLE_BITS-1:0]              i_shift_in,
    input  logic signed [SAMPLE_BITS-1:0]              i_ring_sample,
    input  logic signed [SAMPLE_BITS-1:0]              i_ring_val,
    input  logic [f_idx_bits(MAX_WINDOW)-1:0]          i_ring_idx,
    output logic signed [SAMPLE_BITS-1:0]              o_sample,
    output logic signed [SAMPLE_BITS-1:0]              o_ring_val,
    output logic [f_idx_bits(MAX_WINDOW)-1:0]          o_ring_idx,
    output logic [SAMPLE_BITS-1:0]                     o_hit_lo,
    output logic [SAMPLE_BITS-1:0]                     o_hit_hi,
    output logic                                       o_match_lo,
    output logic                                       o_match_hi
);

    localparam int IDXW = f_idx_bits(MAX_WINDOW);
    localparam int LW   = f_len_bits(MAX_WINDOW);
    localparam logic [IDXW-1:0] SELF_IDX = IDXW'(CELL_IDX);
    localparam logic [IDXW-1:0] PREV_IDX = IDXW'((CELL_IDX + MAX_WINDOW - 1) % MAX_WINDOW);

    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic signed [SAMPLE_BITS-1:0] r_ring_val;
    logic [IDXW-1:0]               r_ring_idx;
    logic [IDXW-1:0]               r_rank;
    logic [SAMPLE_BITS-1:0]        r_hit_lo;
    logic [SAMPLE_BITS-1:0]        r_hit_hi;
    logic                          r_match_lo;
    logic                          r_match_hi;

    logic w_before;
    logic w_active;
    logic n_match_lo;
    logic n_match_hi;

    // The passing sample ranks below ours; ties go to the newer slot.
    assign w_before = (LW'(r_ring_idx) < i_len) &&
                      ((r_ring_val < r_sample) ||
                       ((r_ring_val == r_sample) && (r_ring_idx < SELF_IDX)));
    assign w_active   = (LW'(SELF_IDX) < i_len);
    assign n_match_lo = w_active && (LW'(r_rank) == i_lo_rank);
    assign n_match_hi = w_active && (LW'(r_rank) == i_hi_rank);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample <= '0;
        end else if (i_ctrl.shift) begin
            r_sample <= i_shift_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_ring_val <= i_ring_sample;
            r_ring_idx <= PREV_IDX;
            r_rank     <= '0;
        end else if (i_ctrl.count) begin
            r_ring_val <= i_ring_val;
            r_ring_idx <= i_ring_idx;
            r_rank     <= r_rank + IDXW'(w_before);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.pick) begin
            r_match_lo <= n_match_lo;
            r_match_hi <= n_match_hi;
            r_hit_lo   <= n_match_lo ? r_sample : '0;
            r_hit_hi   <= n_match_hi ? r_sample : '0;
        end
    end

    assign o_sample   = r_sample;
    assign o_ring_val = r_ring_val;
    assign o_ring_idx = r_ring_idx;
    assign o_hit_lo   = r_hit_lo;
    assign o_hit_hi   = r_hit_hi;
    assign o_match_lo = r_match_lo;
    assign o_match_hi = r_match_hi;

endmodule

// ===== rtl/swmf_ctrl.sv =====
// Sequencer: shift, load, rank count, pick and sum phases for one item.
module swmf_ctrl
    import swmf_pkg::*;
#(
    parameter int MAX_WINDOW = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    output t_cell_ctrl o_ctrl,
    input  logic       i_out_free
);

    localparam int IDXW = f_idx_bits(MAX_WINDOW);
    localparam logic [IDXW-1:0] LAST_STEP = IDXW'(MAX_WINDOW - 1);

    t_state          r_state;
    t_state          n_state;
    logic [IDXW-1:0] r_step;
    logic [IDXW-1:0] n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_step  = IDXW'(1);
                n_state = (MAX_WINDOW == 1) ? S_PICK : S_COUNT;
            end
            S_COUNT: begin
                n_step = r_step + IDXW'(1);
                if (r_step == LAST_STEP) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                n_state = S_SUM;
            end
            S_SUM: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_ctrl  = '0;
        case (r_state)
            S_IDLE: begin
                o_ready      = 1'b1;
                o_ctrl.shift = i_valid;
            end
            S_LOAD:  o_ctrl.load  = 1'b1;
            S_COUNT: o_ctrl.count = 1'b1;
            S_PICK:  o_ctrl.pick  = 1'b1;
            S_SUM:   o_ctrl.sum   = 1'b1;
            default: o_ctrl = '0;
        endcase
    end

endmodule
